// ===== rtl/core/mt3sc_pkg.sv =====
// ----------------------------------------------------------------------------
// mt3sc_pkg
// Types and constants shared by the masked top-3 score classifier and the
// interfaces that carry its score items and ranked results.
// ----------------------------------------------------------------------------
package mt3sc_pkg;

    localparam int SCORE_W    = 8;
    localparam int IDX_W      = 10;
    localparam int PCT_W      = 8;
    localparam int RANK_W     = 2;
    localparam int THR_W      = 7;
    localparam int SCALE_W    = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    // Q16 fraction width and the saturation limit of a percentage.
    localparam int PCT_FRAC_W = 16;
    localparam logic [PCT_W-1:0] PCT_MAX = 8'd255;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REGION_ON = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_PT   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE     = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0]          RST_THRESHOLD = 7'd50;
    localparam logic                      RST_REGION_ON = 1'b0;
    localparam logic signed [SCORE_W-1:0] RST_ZERO_PT   = 8'sd0;
    localparam logic [SCALE_W-1:0]        RST_SCALE     = 24'd256;

    typedef enum logic [1:0] {
        VERDICT_SPECIES = 2'd0,
        VERDICT_NO_BIRD = 2'd1,
        VERDICT_UNKNOWN = 2'd2
    } t_verdict;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      in_region;
        logic                      is_background;
        logic                      last_class;
    } t_in_item;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              valid_res;
        logic [IDX_W-1:0]  class_index;
        logic [PCT_W-1:0]  percent;
        t_verdict          verdict;
        logic              final_result;
    } t_out_item;

endpackage

// ===== rtl/core/mt3sc_in_if.sv =====
// ----------------------------------------------------------------------------
// mt3sc_in_if
// Valid/ready channel that carries one class score item per transfer.
// ----------------------------------------------------------------------------
interface mt3sc_in_if;
    import mt3sc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/mt3sc_out_if.sv =====
// ----------------------------------------------------------------------------
// mt3sc_out_if
// Valid/ready channel that carries one ranked result per transfer.
// ----------------------------------------------------------------------------
interface mt3sc_out_if;
    import mt3sc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/masked_top3_score_classifier.sv =====
// ----------------------------------------------------------------------------
// masked_top3_score_classifier
// Streaming top-K selection over int8 class scores with region masking,
// Q16 dequantization to percent and a frame verdict.
// ----------------------------------------------------------------------------
// Throughput: one score item per cycle; the top-K table compares all entries
//   in parallel. A last item waits only while the previous frame's results
//   (TOP_COUNT of them) are still draining from the result bank.
// Output: the last item's transfer loads the result bank; rank 0 is then registered
//   into the output register, then one result per cycle as the sink takes them.
// Reset: configuration returns to its defaults, the table and bank are empty.
module masked_top3_score_classifier #(
    parameter int MAX_CLASSES = 1024,
    parameter int TOP_COUNT   = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mt3sc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [mt3sc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    mt3sc_in_if.sink                        i_item,
    mt3sc_out_if.source                     o_result
);
    import mt3sc_pkg::*;

    localparam int CNT_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int PTR_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    // Configuration registers.
    logic [THR_W-1:0]          r_threshold;
    logic                      r_region_on;
    logic signed [SCORE_W-1:0] r_zero_pt;
    logic [SCALE_W-1:0]        r_scale;

    // Working top-K table, sorted best first; filled entries form a prefix.
    logic signed [SCORE_W-1:0] r_score [TOP_COUNT];
    logic [IDX_W-1:0]          r_index [TOP_COUNT];
    logic [TOP_COUNT-1:0]      r_bg;
    logic [TOP_COUNT-1:0]      r_filled;
    logic [CNT_W-1:0]          r_cnt;

    logic signed [SCORE_W-1:0] n_score [TOP_COUNT];
    logic [IDX_W-1:0]          n_index [TOP_COUNT];
    logic [TOP_COUNT-1:0]      n_bg;
    logic [TOP_COUNT-1:0]      n_filled;
    logic [CNT_W-1:0]          n_cnt;

    // Result bank, loaded from the table at the end of a frame.
    logic signed [SCORE_W-1:0] r_bk_score [TOP_COUNT];
    logic [IDX_W-1:0]          r_bk_index [TOP_COUNT];
    logic [TOP_COUNT-1:0]      r_bk_bg;
    logic [TOP_COUNT-1:0]      r_bk_filled;
    logic                      r_bank_busy;
    logic [PTR_W-1:0]          r_ptr;
    t_verdict                  r_verdict;

    logic      r_out_valid;
    t_out_item r_out;

    logic                 in_fire;
    logic                 take;
    logic                 drain_fire;
    logic                 drain_last;
    logic [TOP_COUNT-1:0] cond;
    logic [CNT_W+IDX_W-1:0] cnt_ext;
    logic [IDX_W-1:0]     cur_index;
    logic [PTR_W+RANK_W-1:0] ptr_ext;
    logic [PCT_W-1:0]     cur_pct;
    t_verdict             cur_verdict;

    // Rounded, saturated (score - zero point) * scale in Q16.
    function automatic logic [PCT_W-1:0] f_percent(
        input logic signed [SCORE_W-1:0] s,
        input logic signed [SCORE_W-1:0] zp,
        input logic [SCALE_W-1:0]        sc
    );
        logic signed [SCORE_W:0]          d;
        logic signed [SCORE_W+SCALE_W+1:0] p;
        logic [SCORE_W+SCALE_W+1:0]        q;
        d = $signed({s[SCORE_W-1], s}) - $signed({zp[SCORE_W-1], zp});
        p = $signed({{(SCALE_W+1){d[SCORE_W]}}, d}) * $signed({{(SCORE_W+2){1'b0}}, sc});
        q = $unsigned(p) + (SCORE_W+SCALE_W+2)'(1 << (PCT_FRAC_W - 1));
        if (p[SCORE_W+SCALE_W+1]) begin
            f_percent = '0;
        end else if (q[SCORE_W+SCALE_W+1:PCT_FRAC_W] > (SCORE_W+SCALE_W+2-PCT_FRAC_W)'(PCT_MAX)) begin
            f_percent = PCT_MAX;
        end else begin
            f_percent = q[PCT_FRAC_W+PCT_W-1:PCT_FRAC_W];
        end
    endfunction

    // A last item may only enter while the bank is free to receive the table.
    assign i_item.ready = !(r_bank_busy && i_item.payload.last_class);
    assign in_fire      = i_item.valid && i_item.ready;
    assign take         = in_fire && !(r_region_on && !i_item.payload.in_region);

    assign cnt_ext   = {{IDX_W{1'b0}}, r_cnt};
    assign cur_index = cnt_ext[IDX_W-1:0];

    always_comb begin
        for (int k = 0; k < TOP_COUNT; k++) begin
            cond[k] = !r_filled[k] || (i_item.payload.score > r_score[k]);
        end
    end

    // Insertion: entries at and below the first winning slot shift down by one.
    always_comb begin
        for (int k = 0; k < TOP_COUNT; k++) begin
            n_score[k]  = r_score[k];
            n_index[k]  = r_index[k];
            n_bg[k]     = r_bg[k];
            n_filled[k] = r_filled[k];
            if (take && cond[k]) begin
                if (k > 0 && cond[(k > 0) ? k - 1 : 0]) begin
                    n_score[k]  = r_score[(k > 0) ? k - 1 : 0];
                    n_index[k]  = r_index[(k > 0) ? k - 1 : 0];
                    n_bg[k]     = r_bg[(k > 0) ? k - 1 : 0];
                    n_filled[k] = r_filled[(k > 0) ? k - 1 : 0];
                end else begin
                    n_score[k]  = i_item.payload.score;
                    n_index[k]  = cur_index;
                    n_bg[k]     = i_item.payload.is_background;
                    n_filled[k] = 1'b1;
                end
            end
        end
        if (r_cnt == CNT_W'(MAX_CLASSES - 1)) begin
            n_cnt = '0;
        end else begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_region_on <= RST_REGION_ON;
            r_zero_pt   <= RST_ZERO_PT;
            r_scale     <= RST_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata[THR_W-1:0];
                CFG_REGION_ON: r_region_on <= i_cfg_wdata[0];
                CFG_ZERO_PT:   r_zero_pt   <= $signed(i_cfg_wdata[SCORE_W-1:0]);
                CFG_SCALE:     r_scale     <= i_cfg_wdata[SCALE_W-1:0];
                default:       r_scale     <= r_scale;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_cnt    <= '0;
        end else if (in_fire) begin
            if (i_item.payload.last_class) begin
                r_filled <= '0;
                r_cnt    <= '0;
            end else begin
                r_filled <= n_filled;
                r_cnt    <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_score <= n_score;
            r_index <= n_index;
            r_bg    <= n_bg;
        end
        if (in_fire && i_item.payload.last_class) begin
            r_bk_score  <= n_score;
            r_bk_index  <= n_index;
            r_bk_bg     <= n_bg;
        end
    end

    // Drain the bank one rank per cycle into the output register while that register is free or being taken.
    assign drain_fire = r_bank_busy && (!r_out_valid || o_result.ready);
    assign drain_last = (r_ptr == PTR_W'(TOP_COUNT - 1));
    assign ptr_ext    = {{RANK_W{1'b0}}, r_ptr};
    assign cur_pct    = f_percent(r_bk_score[r_ptr], r_zero_pt, r_scale);

    always_comb begin
        cur_verdict = VERDICT_UNKNOWN;
        if (r_bk_filled[0] && cur_pct >= {1'b0, r_threshold}) begin
            cur_verdict = r_bk_bg[0] ? VERDICT_NO_BIRD : VERDICT_SPECIES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_busy <= 1'b0;
            r_bk_filled <= '0;
            r_ptr       <= '0;
            r_verdict   <= VERDICT_UNKNOWN;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire && i_item.payload.last_class) begin
                r_bank_busy <= 1'b1;
                r_bk_filled <= n_filled;
                r_ptr       <= '0;
            end else if (drain_fire) begin
                if (drain_last) begin
                    r_bank_busy <= 1'b0;
                    r_ptr       <= '0;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
                if (r_ptr == '0) begin
                    r_verdict <= cur_verdict;
                end
            end
            if (drain_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Verdict is formed from rank 0 and reused for the rest of the frame.
    always_ff @(posedge i_clk) begin
        if (drain_fire) begin
            r_out.rank         <= ptr_ext[RANK_W-1:0];
            r_out.valid_res    <= r_bk_filled[r_ptr];
            r_out.class_index  <= r_bk_filled[r_ptr] ? r_bk_index[r_ptr] : '0;
            r_out.percent      <= r_bk_filled[r_ptr] ? cur_pct : '0;
            r_out.verdict      <= (r_ptr == '0) ? cur_verdict : r_verdict;
            r_out.final_result <= drain_last;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    // Filled entries always form a prefix of the table.
    logic [TOP_COUNT:0] filled_ext;
    assign filled_ext = {1'b0, r_filled};

    a_filled_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((filled_ext + 1'b1) & filled_ext) == '0)
        else $error("top-K table has a gap in its filled entries");

    a_last_needs_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_item.payload.last_class) |-> !r_bank_busy)
        else $error("frame end transferred while result bank still draining");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (drain_fire && drain_last && !(in_fire && i_item.payload.last_class))
            |=> (!r_bank_busy && r_out_valid && r_out.final_result))
        else $error("bank drain did not finish with the final result");

    a_empty_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.valid_res) |-> (r_out.percent == '0 && r_out.class_index == '0))
        else $error("empty rank carries a class or a percentage");

    a_empty_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (drain_fire && r_ptr == '0 && !r_bk_filled[0]) |=> (r_out.verdict == VERDICT_UNKNOWN))
        else $error("frame without candidates gave a definite verdict");

endmodule

// ===== tb/sv/tb_masked_top3_score_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_masked_top3_score_classifier
// Self-checking bench for the masked top-3 score classifier. Score frames are
// streamed in over the item channel, and a model of the ranking table,
// percent conversion and frame verdict predicts the three ranked results of
// each frame. Directed frames cover ties, saturation, rounding, background
// verdicts, region skipping and counter wrap. Random frames follow, under
// several idle and stall mixes and a long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_masked_top3_score_classifier;
    import mt3sc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOP_N = 3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    mt3sc_in_if  score_ch ();
    mt3sc_out_if rank_ch ();

    masked_top3_score_classifier DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (score_ch),
        .o_result    (rank_ch)
    );

    // Mirror of the configuration registers.
    logic [THR_W-1:0]          cfg_threshold = RST_THRESHOLD;
    logic                      cfg_region_on = RST_REGION_ON;
    logic signed [SCORE_W-1:0] cfg_zero_pt   = RST_ZERO_PT;
    logic [SCALE_W-1:0]        cfg_scale     = RST_SCALE;

    // Mirror of the ranking table.
    logic signed [SCORE_W-1:0] top_score [TOP_N] = '{default: '0};
    logic [IDX_W-1:0]          top_index [TOP_N] = '{default: '0};
    logic                      top_bg    [TOP_N] = '{default: 1'b0};
    logic                      top_used  [TOP_N] = '{default: 1'b0};
    logic [IDX_W-1:0]          class_count = '0;

    t_out_item ranked_q [$];
    int        errors = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    int        rx_hold_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [PCT_W-1:0] score_pct(logic signed [SCORE_W-1:0] s);
        longint prod;
        prod = (longint'(s) - longint'(cfg_zero_pt)) * longint'(cfg_scale);
        if (prod < 0) return '0;
        prod = (prod + 64'sd32768) >>> PCT_FRAC_W;
        if (prod > 255) return PCT_MAX;
        return prod[PCT_W-1:0];
    endfunction

    // Updates the table with one accepted score and, at the end of a frame,
    // queues the three ranked results and clears the frame state.
    function automatic void rank_score(t_in_item it);
        logic signed [SCORE_W-1:0] s;
        logic                      placed;
        t_verdict                  verdict;
        t_out_item                 r;
        s = it.score;
        placed = 1'b0;
        if (!(cfg_region_on && !it.in_region)) begin
            for (int k = 0; k < TOP_N; k++) begin
                if (!placed && (!top_used[k] || s > top_score[k])) begin
                    for (int m = TOP_N - 1; m > k; m--) begin
                        top_score[m] = top_score[m-1];
                        top_index[m] = top_index[m-1];
                        top_bg[m]    = top_bg[m-1];
                        top_used[m]  = top_used[m-1];
                    end
                    top_score[k] = s;
                    top_index[k] = class_count;
                    top_bg[k]    = it.is_background;
                    top_used[k]  = 1'b1;
                    placed = 1'b1;
                end
            end
        end
        class_count = class_count + 1'b1;
        if (!it.last_class) return;

        verdict = VERDICT_UNKNOWN;
        if (top_used[0] && score_pct(top_score[0]) >= {1'b0, cfg_threshold})
            verdict = top_bg[0] ? VERDICT_NO_BIRD : VERDICT_SPECIES;
        for (int k = 0; k < TOP_N; k++) begin
            r.rank         = RANK_W'(k);
            r.valid_res    = top_used[k];
            r.class_index  = top_used[k] ? top_index[k] : '0;
            r.percent      = top_used[k] ? score_pct(top_score[k]) : '0;
            r.verdict      = verdict;
            r.final_result = (k == TOP_N - 1);
            ranked_q.push_back(r);
            top_used[k] = 1'b0;
        end
        class_count = '0;
    endfunction

    function automatic t_in_item mk_item(int s, bit reg_ok, bit bg, bit last);
        t_in_item it;
        it.score         = SCORE_W'(s);
        it.in_region     = reg_ok;
        it.is_background = bg;
        it.last_class    = last;
        return it;
    endfunction

    // Called right after a rising edge; returns right after the transfer.
    task automatic send_score(t_in_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            score_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        score_ch.valid   <= 1'b1;
        score_ch.payload <= it;
        @(posedge i_clk);
        while (!score_ch.ready) @(posedge i_clk);
        rank_score(it);
    endtask

    // Stops offering items and waits until every queued result has arrived,
    // then idles so that the result pipeline settles.
    task automatic wait_idle();
        score_ch.valid <= 1'b0;
        while (ranked_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (addr)
            CFG_THRESHOLD: cfg_threshold = data[THR_W-1:0];
            CFG_REGION_ON: cfg_region_on = data[0];
            CFG_ZERO_PT:   cfg_zero_pt   = data[SCORE_W-1:0];
            CFG_SCALE:     cfg_scale     = data[SCALE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] junk;
        int                    pick;
        wait_idle();
        // Bits above a narrow register's width carry noise; they must be ignored.
        junk = CFG_DATA_W'($urandom);
        pick = $urandom_range(0, 3);
        write_cfg(CFG_THRESHOLD, {junk[CFG_DATA_W-1:THR_W],
            THR_W'(pick == 0 ? 0 : pick == 1 ? 127 : $urandom_range(0, 100))});
        junk = CFG_DATA_W'($urandom);
        write_cfg(CFG_REGION_ON, {junk[CFG_DATA_W-1:1], 1'($urandom_range(0, 1))});
        junk = CFG_DATA_W'($urandom);
        pick = $urandom_range(0, 4);
        write_cfg(CFG_ZERO_PT, {junk[CFG_DATA_W-1:SCORE_W],
            SCORE_W'(pick == 0 ? -128 : pick == 1 ? 127 :
                     pick == 2 ? $urandom_range(0, 255) : $urandom_range(0, 40) - 20)});
        pick = $urandom_range(0, 4);
        case (pick)
            0: write_cfg(CFG_SCALE, CFG_DATA_W'($urandom_range(0, 2000)));
            1: write_cfg(CFG_SCALE, CFG_DATA_W'($urandom_range(10000, 60000)));
            2: write_cfg(CFG_SCALE, CFG_DATA_W'($urandom));
            3: write_cfg(CFG_SCALE, '1);
            default: write_cfg(CFG_SCALE, CFG_DATA_W'($urandom_range(0, 1) ? 0 : 32768));
        endcase
    endtask

    // Sends one frame of random scores; returns the number of items sent.
    task automatic send_random_frame(output int n);
        int base;
        int s;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
        base = $urandom_range(0, 255) - 128;
        for (int i = 0; i < n; i++) begin
            // A narrow band around one value now and then makes ties common.
            if ($urandom_range(0, 3) == 0) begin
                s = base + $urandom_range(0, 2) - 1;
                if (s > 127) s = 127;
                if (s < -128) s = -128;
            end else begin
                s = $urandom_range(0, 255) - 128;
            end
            send_score(mk_item(s, $urandom_range(0, 3) != 0, $urandom_range(0, 9) == 0,
                               i == n - 1));
        end
    endtask

    task automatic test_reset_defaults();
        // Reset scale makes every percent round to zero.
        send_score(mk_item(127, 1'b1, 1'b0, 1'b1));
        send_score(mk_item(-128, 1'b0, 1'b0, 1'b0));
        send_score(mk_item(-128, 1'b1, 1'b1, 1'b1));
        wait_idle();
    endtask

    task automatic test_ranking_and_verdicts();
        // Half a percent per step: rounding half up, ties keep the earlier class.
        write_cfg(CFG_SCALE, 24'd32768);
        write_cfg(CFG_THRESHOLD, '0);
        send_score(mk_item(1, 1'b1, 1'b0, 1'b0));
        send_score(mk_item(-1, 1'b1, 1'b0, 1'b0));
        send_score(mk_item(1, 1'b1, 1'b1, 1'b0));
        send_score(mk_item(0, 1'b1, 1'b0, 1'b1));
        wait_idle();

        // Largest scale and threshold: saturation, confident species and background.
        write_cfg(CFG_SCALE, '1);
        write_cfg(CFG_ZERO_PT, CFG_DATA_W'(8'sh80));
        write_cfg(CFG_THRESHOLD, CFG_DATA_W'(127));
        send_score(mk_item(-128, 1'b1, 1'b1, 1'b0));
        send_score(mk_item(127, 1'b1, 1'b0, 1'b0));
        send_score(mk_item(-128, 1'b1, 1'b0, 1'b1));
        send_score(mk_item(100, 1'b1, 1'b1, 1'b0));
        send_score(mk_item(50, 1'b1, 1'b0, 1'b0));
        send_score(mk_item(-5, 1'b1, 1'b0, 1'b1));
        wait_idle();

        // Negative products clamp to zero; a weak background top is unidentified.
        write_cfg(CFG_ZERO_PT, CFG_DATA_W'(127));
        write_cfg(CFG_REGION_ON, CFG_DATA_W'(1));
        send_score(mk_item(126, 1'b1, 1'b0, 1'b0));
        send_score(mk_item(-128, 1'b0, 1'b0, 1'b0));
        send_score(mk_item(127, 1'b1, 1'b1, 1'b1));
        wait_idle();
        // Every class outside the region: no candidate at all.
        send_score(mk_item(5, 1'b0, 1'b0, 1'b0));
        send_score(mk_item(7, 1'b0, 1'b1, 1'b1));
        wait_idle();

        // A species below the threshold is unidentified.
        write_cfg(CFG_ZERO_PT, '0);
        write_cfg(CFG_SCALE, 24'd25600);
        write_cfg(CFG_THRESHOLD, CFG_DATA_W'(50));
        send_score(mk_item(60, 1'b1, 1'b0, 1'b0));
        send_score(mk_item(20, 1'b1, 1'b0, 1'b1));
        wait_idle();
    endtask

    task automatic test_counter_wrap();
        int n;
        n = (1 << IDX_W) + 6;
        write_cfg(CFG_REGION_ON, '0);
        for (int i = 0; i < n; i++) begin
            // The best scores sit past the wrap point of the class counter.
            if (i < (1 << IDX_W))
                send_score(mk_item($urandom_range(0, 150) - 128, 1'($urandom), 1'b0, 1'b0));
            else
                send_score(mk_item(100 + i - (1 << IDX_W), 1'b1, 1'b0, i == n - 1));
        end
        wait_idle();
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct, int n_items);
        int sent;
        int n;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        random_config();
        sent = 0;
        while (sent < n_items) begin
            send_random_frame(n);
            sent += n;
            if ($urandom_range(0, 5) == 0) random_config();
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        int n;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        random_config();
        // Results pile up while the sink holds off; the item channel must stall.
        rx_hold_left = 150;
        for (int f = 0; f < 20; f++) begin
            if (f % 2 == 0)
                send_score(mk_item($urandom_range(0, 255) - 128, 1'b1, 1'($urandom), 1'b1));
            else
                send_random_frame(n);
        end
        wait_idle();
        rx_stall_pct = 46;
        for (int f = 0; f < 6; f++) send_random_frame(n);
        wait_idle();
    endtask

    // Result sink: random stalls plus an optional long hold-off.
    initial begin
        rank_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                rank_ch.ready <= 1'b0;
            end else begin
                rank_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Result checker.
    initial begin
        t_out_item got;
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rank_ch.valid && rank_ch.ready) begin
                got = rank_ch.payload;
                if (ranked_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got rank=%0d valid=%0b",
                             $time, got.rank, got.valid_res);
                end else begin
                    want = ranked_q.pop_front();
                    if (got.rank !== want.rank || got.valid_res !== want.valid_res ||
                        got.class_index !== want.class_index ||
                        got.percent !== want.percent || got.verdict !== want.verdict ||
                        got.final_result !== want.final_result) begin
                        errors++;
                        $display("%0t: mismatch: expected rank=%0d valid=%0b idx=%0d pct=%0d verdict=%0d final=%0b",
                                 $time, want.rank, want.valid_res, want.class_index,
                                 want.percent, want.verdict, want.final_result);
                        $display("%0t:           actual rank=%0d valid=%0b idx=%0d pct=%0d verdict=%0d final=%0b",
                                 $time, got.rank, got.valid_res, got.class_index,
                                 got.percent, got.verdict, got.final_result);
                    end
                end
            end
        end
    end

    initial begin
        score_ch.valid   <= 1'b0;
        score_ch.payload <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_ranking_and_verdicts();
        test_counter_wrap();
        test_random_traffic(0, 0, 75);
        test_random_traffic(46, 0, 75);
        test_random_traffic(0, 46, 75);
        test_random_traffic(21, 21, 75);
        test_backpressure();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (ranked_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, ranked_q.size());
        end
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
